>>> sv/assert_macros.svh
// assertion macros included by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

>>> sv/ntfe_pkg.sv
// constants, types and helpers for the nmea time and fix extractor
`default_nettype none

package ntfe_pkg;

  localparam int MaxSentenceBytes = 128;
  localparam int LineLenW = 8;
  localparam int ValW = 7;
  localparam int OutW = 48;

  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_LINE  = 4'b0010,
    PH_OVER  = 4'b0100,
    PH_SKIP  = 4'b1000
  } phase_e;

  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_GGA   = 3'd1;
  localparam logic [2:0] KIND_GLL   = 3'd2;
  localparam logic [2:0] KIND_GSA   = 3'd3;
  localparam logic [2:0] KIND_GSV   = 3'd4;
  localparam logic [2:0] KIND_RMC   = 3'd5;
  localparam logic [2:0] KIND_VTG   = 3'd6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam int FLAG_FIX  = 0;
  localparam int FLAG_TIME = 1;
  localparam int FLAG_DATE = 2;

  localparam logic       REG_SYNC_ENABLE = 1'b0;
  localparam logic       REG_LAG_RELOAD  = 1'b1;

  localparam int FieldTime = 1;
  localparam int FieldFix  = 6;
  localparam int FieldDate = 9;
  localparam int BaseDate  = 3;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
  endfunction

  function automatic logic [2:0] kind_of(input logic [23:0] tag);
    logic [2:0] k;
    case (tag)
      24'h474741: k = KIND_GGA;
      24'h474C4C: k = KIND_GLL;
      24'h475341: k = KIND_GSA;
      24'h475356: k = KIND_GSV;
      24'h524D43: k = KIND_RMC;
      24'h565447: k = KIND_VTG;
      default:    k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> sv/nmea_time_fix_extractor_top.sv
// nmea time and fix extractor: one byte per transaction, one report per line end of a $ sentence
// path: a byte is registered in the input register, processed, and its report sits in the
// output register, so a terminator passes the input register and then the output register
// throughput: one byte per cycle while the output side takes reports; a report
// held by the output side stalls the input until it is taken
// reset returns all parser state to its start values; sync_enable resets to 1 and lag_reload to 60
`default_nettype none
`include "assert_macros.svh"

module nmea_time_fix_extractor_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [7:0]                s_axis_tdata,   // in_byte
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // sentence_kind, hour_out, minute_out, second_out, day_out, month_out,
  // year_out, has_fix, set_time, zero pad
  output logic [ntfe_pkg::OutW-1:0]      m_axis_tdata,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [15:0]               cfg_data_i
);
  import ntfe_pkg::*;

  logic        sync_en_q;
  logic [15:0] lag_reload_q;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        advance;

  phase_e              phase_q, phase_d;
  logic [3:0]          field_num_q, field_num_d;
  logic [LineLenW-1:0] line_len_q, line_len_d;
  logic [3:0]          field_len_q, field_len_d;
  logic [23:0]         tag_q, tag_d;
  logic [2:0]          kind_q, kind_d;
  logic [3:0]          first_digit_q, first_digit_d;
  logic                fix_seen_q, fix_seen_d;
  logic                fix_nz_q, fix_nz_d;
  logic                scan_live_q, scan_live_d;
  logic [ValW-1:0]     clk_fields_q [6];
  logic [ValW-1:0]     clk_fields_d [6];
  logic [2:0]          flags_q, flags_d;
  logic [15:0]         lag_q, lag_d;

  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [ValW-1:0] out_vals_q [6];
  logic        out_fix_q;
  logic        out_pulse_q;

  logic        emit;
  logic        pulse;
  logic        do_char, do_field_end, do_line_end;
  logic        in_time, in_date, in_pair, in_fix_field;
  logic [2:0]  pidx_char, pidx_end;
  logic [7:0]  c;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign c             = in_byte_q;

  assign in_time      = (field_num_q == 4'(FieldTime)) &&
                        ((kind_q == KIND_GGA) || (kind_q == KIND_RMC));
  assign in_date      = (field_num_q == 4'(FieldDate)) && (kind_q == KIND_RMC);
  assign in_pair      = in_time || in_date;
  assign in_fix_field = (field_num_q == 4'(FieldFix)) && (kind_q == KIND_GGA);
  assign pidx_char    = (in_date ? 3'(BaseDate) : 3'd0) + {1'b0, field_len_q[2:1]};
  assign pidx_end     = pidx_char;

  always_comb begin
    phase_d       = phase_q;
    field_num_d   = field_num_q;
    line_len_d    = line_len_q;
    field_len_d   = field_len_q;
    tag_d         = tag_q;
    kind_d        = kind_q;
    first_digit_d = first_digit_q;
    fix_seen_d    = fix_seen_q;
    fix_nz_d      = fix_nz_q;
    scan_live_d   = scan_live_q;
    clk_fields_d  = clk_fields_q;
    flags_d       = flags_q;
    lag_d         = lag_q;
    do_char       = 1'b0;
    do_field_end  = 1'b0;
    do_line_end   = 1'b0;
    pulse         = 1'b0;

    if (advance) begin
      case (phase_q)
        PH_START: begin
          if (!is_term(c)) begin
            if (c == CH_DOLLAR && sync_en_q) begin
              phase_d     = PH_LINE;
              line_len_d  = LineLenW'(1);
              field_num_d = 4'd0;
              tag_d       = 24'd0;
              kind_d      = KIND_OTHER;
              field_len_d = 4'd0;
              scan_live_d = 1'b1;
              fix_seen_d  = 1'b0;
              fix_nz_d    = 1'b0;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_LINE: begin
          if (is_term(c)) begin
            do_field_end = 1'b1;
            do_line_end  = 1'b1;
          end else if (line_len_q >= LineLenW'(MaxSentenceBytes)) begin
            phase_d = PH_OVER;
          end else begin
            line_len_d = line_len_q + LineLenW'(1);
            if (c == CH_COMMA) begin
              do_field_end = 1'b1;
            end else if (c != CH_DOLLAR && c != CH_BANG) begin
              do_char = 1'b1;
            end
          end
        end
        PH_OVER: begin
          if (is_term(c)) begin
            do_field_end = 1'b1;
            do_line_end  = 1'b1;
          end
        end
        PH_SKIP: begin
          if (is_term(c)) begin
            phase_d = PH_START;
          end
        end
        default: begin
          phase_d = PH_START;
        end
      endcase
    end

    if (do_char) begin
      if (field_num_q == 4'd0) begin
        tag_d = {tag_q[15:0], c};
      end else if (in_pair) begin
        if (scan_live_q && field_len_q < 4'd6) begin
          if (is_digit(c)) begin
            if (!field_len_q[0]) begin
              first_digit_d = c[3:0];
            end else begin
              clk_fields_d[pidx_char] = (ValW'(first_digit_q) * ValW'(10)) + ValW'(c[3:0]);
            end
          end else begin
            if (field_len_q[0]) begin
              clk_fields_d[pidx_char] = ValW'(first_digit_q);
            end
            scan_live_d = 1'b0;
          end
        end
      end else if (in_fix_field && scan_live_q) begin
        if (is_digit(c)) begin
          fix_seen_d = 1'b1;
          if (c != CH_ZERO) begin
            fix_nz_d = 1'b1;
          end
        end else begin
          scan_live_d = 1'b0;
        end
      end
      if (field_len_q != 4'hF) begin
        field_len_d = field_len_q + 4'd1;
      end
    end

    if (do_field_end) begin
      if (field_num_q == 4'd0) begin
        kind_d = (field_len_q == 4'd5) ? kind_of(tag_q) : KIND_OTHER;
      end else if (in_pair) begin
        if (scan_live_q && field_len_q < 4'd6 && field_len_q[0]) begin
          clk_fields_d[pidx_end] = ValW'(first_digit_q);
        end
        if (in_date && field_len_q != 4'd0) begin
          flags_d[FLAG_DATE] = 1'b1;
        end
      end else if (in_fix_field) begin
        if (fix_seen_q && fix_nz_q) begin
          flags_d[FLAG_FIX]  = 1'b1;
          flags_d[FLAG_TIME] = 1'b1;
        end else begin
          flags_d[FLAG_FIX] = 1'b0;
        end
      end
      if (field_num_q != 4'hF) begin
        field_num_d = field_num_q + 4'd1;
      end
      field_len_d = 4'd0;
      scan_live_d = 1'b1;
      fix_seen_d  = 1'b0;
      fix_nz_d    = 1'b0;
    end

    if (do_line_end) begin
      if (&flags_d) begin
        flags_d[FLAG_TIME] = 1'b0;
        flags_d[FLAG_DATE] = 1'b0;
        if (lag_q == 16'd0) begin
          pulse = 1'b1;
          lag_d = lag_reload_q - 16'd1;
        end else begin
          lag_d = lag_q - 16'd1;
        end
      end
      phase_d = PH_START;
    end
  end

  assign emit = do_line_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_en_q    <= 1'b1;
      lag_reload_q <= 16'd60;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYNC_ENABLE: sync_en_q    <= cfg_data_i[0];
        REG_LAG_RELOAD:  lag_reload_q <= cfg_data_i;
        default:         sync_en_q    <= sync_en_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_START;
      field_num_q   <= 4'd0;
      line_len_q    <= '0;
      field_len_q   <= 4'd0;
      tag_q         <= 24'd0;
      kind_q        <= KIND_OTHER;
      first_digit_q <= 4'd0;
      fix_seen_q    <= 1'b0;
      fix_nz_q      <= 1'b0;
      scan_live_q   <= 1'b1;
      for (int i = 0; i < 6; i++) begin
        clk_fields_q[i] <= '0;
      end
      flags_q       <= 3'd0;
      lag_q         <= 16'd0;
    end else begin
      phase_q       <= phase_d;
      field_num_q   <= field_num_d;
      line_len_q    <= line_len_d;
      field_len_q   <= field_len_d;
      tag_q         <= tag_d;
      kind_q        <= kind_d;
      first_digit_q <= first_digit_d;
      fix_seen_q    <= fix_seen_d;
      fix_nz_q      <= fix_nz_d;
      scan_live_q   <= scan_live_d;
      clk_fields_q  <= clk_fields_d;
      flags_q       <= flags_d;
      lag_q         <= lag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_kind_q  <= kind_d;
      out_vals_q  <= clk_fields_d;
      out_fix_q   <= flags_d[FLAG_FIX];
      out_pulse_q <= pulse;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_pulse_q, out_fix_q,
                          out_vals_q[5], out_vals_q[4], out_vals_q[3],
                          out_vals_q[2], out_vals_q[1], out_vals_q[0], out_kind_q};

  // a clock-set pulse needs a fix in the same report
  `ASSERT_PROP(a_pulse_has_fix, clk_i, rst_ni, (m_axis_tvalid && out_pulse_q) |-> out_fix_q)
  // a held input byte is not overwritten
  `ASSERT_PROP(a_in_hold, clk_i, rst_ni, (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q)))
  // reports only come from counted lines
  `ASSERT_NEVER(a_emit_phase, clk_i, rst_ni, emit && (phase_q == PH_START || phase_q == PH_SKIP))

endmodule

`default_nettype wire
